// ===== hdl/urd_pkg.sv =====
// ----------------------------------------------------------------------------
// urd_pkg
// Shared types, constants and the segment decoder of the ultrasonic ranger.
// ----------------------------------------------------------------------------
package urd_pkg;

    // default parameter values
    localparam int NUM_DIGITS_DEF  = 4;
    localparam int WIDTH_COUNT_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_NEAR    = 3'd0;
    localparam logic [2:0] CFG_FAR     = 3'd1;
    localparam logic [2:0] CFG_SCALE   = 3'd2;
    localparam logic [2:0] CFG_HOLD    = 3'd3;
    localparam logic [2:0] CFG_TRIGGER = 3'd4;
    localparam int         CFG_IDX_W   = 3;
    localparam int         CFG_DATA_W  = 16;

    // reset values of the registers
    localparam logic [13:0] NEAR_RST    = 14'd10;
    localparam logic [13:0] FAR_RST     = 14'd200;
    localparam logic [15:0] SCALE_RST   = 16'd7812;
    localparam logic [7:0]  HOLD_RST    = 8'd47;
    localparam logic [3:0]  TRIGGER_RST = 4'd1;

    // ranging phases
    localparam logic [1:0] PH_TRIG = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_MEAS = 2'd2;

    // arithmetic constants
    localparam logic [10:0] DIST_MUL   = 11'd1124;
    localparam int          DIST_SHR   = 10;
    localparam logic [13:0] DIST_MAX   = 14'd9999;
    localparam logic [7:0]  BAND_TOP   = 8'd205;
    localparam logic [7:0]  DEN_BASE   = 8'd210;
    // divide by ten: exact for values up to 9999
    localparam logic [12:0] DEC_RECIP  = 13'd6554;
    localparam int          DEC_SHR    = 16;
    localparam logic [13:0] DEC_BASE   = 14'd10;
    // divide by 25, rounded up: exact for numerators up to 65559
    localparam logic [16:0] NEAR_BIAS  = 17'd24;
    localparam logic [19:0] NEAR_RECIP = 20'd671089;
    localparam int          NEAR_SHR   = 24;
    localparam int          DIV_W      = 20;
    localparam int          DIVR_W     = 8;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul;
        logic dig_store;
        logic iv_go;
        logic iv_direct;
        logic iv_store;
        logic commit;
    } urd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic capture;
        logic last_digit;
        logic iv_div;
        logic div_done;
        logic out_free;
    } urd_sts_t;

    // seven segment pattern, bit0 = segment a
    function automatic logic [6:0] urd_seg(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            4'd9: s = 7'h67;
            default: s = 7'h3F;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/ultrasonic_ranger_display_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_ranger_display_top
// Ultrasonic echo ranger with multiplexed seven-segment display and LED.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  s_       | in        | s_valid/s_ready   | echo level of one timer tick
//  m_       | out       | m_valid/m_ready   | trigger, segments, enables, led,
//           |           |                   | distance, new flag
//  cfg_     | in        | cfg_we            | cfg_index, cfg_data
//
// A tick without a capture goes from idle straight to the final step. A tick
// that captures a distance passes through the multiply, the digit state for
// each digit in turn and the interval selection; in the middle band, where the
// 20-step serial divider forms the interval, it then waits for the divider.
// A new beat is accepted once the previous one sits in the output register;
// a stalled output holds the next beat in its final step.
// Reset is synchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_display_top #(
    parameter int NUM_DIGITS       = urd_pkg::NUM_DIGITS_DEF,
    parameter int WIDTH_COUNT_BITS = urd_pkg::WIDTH_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_echo_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_trigger_out,
    output logic [6:0]                     m_segment_lines,
    output logic [3:0]                     m_digit_enable_n,
    output logic                           m_led_out,
    output logic [13:0]                    m_distance_cm,
    output logic                           m_distance_new,
    input  logic                           cfg_we,
    input  logic [urd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urd_pkg::CFG_DATA_W-1:0] cfg_data
);
    urd_pkg::urd_cmd_t cmd;
    urd_pkg::urd_sts_t sts;

    urd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    urd_dp #(
        .NUM_DIGITS       (NUM_DIGITS),
        .WIDTH_COUNT_BITS (WIDTH_COUNT_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_echo_level     (s_echo_level),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_trigger_out    (m_trigger_out),
        .m_segment_lines  (m_segment_lines),
        .m_digit_enable_n (m_digit_enable_n),
        .m_led_out        (m_led_out),
        .m_distance_cm    (m_distance_cm),
        .m_distance_new   (m_distance_new)
    );

`ifndef ASSERT_OFF
    // distance stays saturated
    a_dist_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_distance_cm <= urd_pkg::DIST_MAX)
        else $error("distance above saturation limit");

    // at most one digit lit
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones(~m_digit_enable_n) <= 1)
        else $error("more than one digit enabled");

    // a capture never happens in the trigger phase
    a_new_no_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_distance_new) |-> !m_trigger_out)
        else $error("capture during trigger phase");
`endif
endmodule

// ===== hdl/urd_div.sv =====
// ----------------------------------------------------------------------------
// urd_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module urd_div #(
    parameter int DW = urd_pkg::DIV_W,
    parameter int VW = urd_pkg::DIVR_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [VW-1:0] rem_reg, dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg, done_reg;
    logic [VW:0]   trial;
    logic          fits;

    // trial subtraction of the next bit
    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    // control: run for DW steps, then pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift the dividend out and the quotient in
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
endmodule

// ===== hdl/urd_ctrl.sv =====
// ----------------------------------------------------------------------------
// urd_ctrl
// Sequencer: ranging step, distance scaling, digit split, interval, output.
// ----------------------------------------------------------------------------
module urd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  urd_pkg::urd_sts_t sts,
    output urd_pkg::urd_cmd_t cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIGIT  = 3'd2;
    localparam logic [2:0] ST_IVSEL  = 3'd3;
    localparam logic [2:0] ST_IVWAIT = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.capture ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIGIT;
            end
            // one decimal digit per cycle, least significant first
            ST_DIGIT: begin
                cmd.dig_store = 1'b1;
                state_next    = sts.last_digit ? ST_IVSEL : ST_DIGIT;
            end
            ST_IVSEL: begin
                if (sts.iv_div) begin
                    cmd.iv_go  = 1'b1;
                    state_next = ST_IVWAIT;
                end else begin
                    cmd.iv_direct = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_IVWAIT: begin
                if (sts.div_done) begin
                    cmd.iv_store = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== hdl/urd_dp.sv =====
// ----------------------------------------------------------------------------
// urd_dp
// Datapath: ranging counters, distance, digits, blink and display scan.
// ----------------------------------------------------------------------------
module urd_dp #(
    parameter int NUM_DIGITS       = urd_pkg::NUM_DIGITS_DEF,
    parameter int WIDTH_COUNT_BITS = urd_pkg::WIDTH_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  urd_pkg::urd_cmd_t                cmd,
    output urd_pkg::urd_sts_t                sts,
    input  logic                             s_echo_level,
    input  logic                             cfg_we,
    input  logic [urd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [urd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_trigger_out,
    output logic [6:0]                       m_segment_lines,
    output logic [3:0]                       m_digit_enable_n,
    output logic                             m_led_out,
    output logic [13:0]                      m_distance_cm,
    output logic                             m_distance_new
);
    localparam int WC = WIDTH_COUNT_BITS;
    localparam int PW = WC + 11;
    localparam int SW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int DW = urd_pkg::DIV_W;
    localparam int VW = urd_pkg::DIVR_W;

    // configuration
    logic [13:0] near_reg, far_reg;
    logic [15:0] scale_reg;
    logic [7:0]  hold_cfg_reg;
    logic [3:0]  trig_cfg_reg;

    // ranging and captured state
    logic [1:0]    phase_reg, phase_next;
    logic [WC-1:0] cnt_reg, cnt_next, c1, width_reg;
    logic          trig_reg, trig_next, fresh_reg, capture_now;
    logic [13:0]   dist_reg;
    logic [3:0]    digit_store [NUM_DIGITS];
    logic [SW-1:0] dig_idx_reg;
    logic [13:0]   dig_val_reg;
    logic [15:0]   iv_reg, bcnt_reg;
    logic          led_reg;
    logic [SW-1:0] scan_reg;
    logic [7:0]    hold_reg;

    // output register
    logic          mv_reg;
    logic          o_trig_reg, o_led_reg, o_new_reg;
    logic [6:0]    o_seg_reg;
    logic [3:0]    o_en_reg;
    logic [13:0]   o_dist_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg     <= urd_pkg::NEAR_RST;
            far_reg      <= urd_pkg::FAR_RST;
            scale_reg    <= urd_pkg::SCALE_RST;
            hold_cfg_reg <= urd_pkg::HOLD_RST;
            trig_cfg_reg <= urd_pkg::TRIGGER_RST;
        end else if (cfg_we) begin
            priority case (cfg_index)
                urd_pkg::CFG_NEAR:    near_reg     <= cfg_data[13:0];
                urd_pkg::CFG_FAR:     far_reg      <= cfg_data[13:0];
                urd_pkg::CFG_SCALE:   scale_reg    <= cfg_data;
                urd_pkg::CFG_HOLD:    hold_cfg_reg <= cfg_data[7:0];
                urd_pkg::CFG_TRIGGER: trig_cfg_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ranging step for the beat on the input
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        trig_next   = 1'b0;
        capture_now = 1'b0;
        c1          = cnt_reg + 1'b1;
        unique case (phase_reg)
            urd_pkg::PH_WAIT: begin
                if (s_echo_level) begin
                    phase_next = urd_pkg::PH_MEAS;
                    cnt_next   = '0;
                end
            end
            urd_pkg::PH_MEAS: begin
                cnt_next = c1;
                if (!s_echo_level) begin
                    capture_now = (c1 != '0);
                    phase_next  = urd_pkg::PH_TRIG;
                    cnt_next    = '0;
                end
            end
            default: begin
                trig_next = 1'b1;
                cnt_next  = c1;
                if (c1 >= WC'((trig_cfg_reg == 4'd0) ? 4'd1 : trig_cfg_reg)) begin
                    phase_next = urd_pkg::PH_WAIT;
                    cnt_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= urd_pkg::PH_TRIG;
            cnt_reg   <= '0;
        end else if (cmd.accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            trig_reg  <= trig_next;
            fresh_reg <= capture_now;
            width_reg <= c1;
        end
    end

    // distance scaling with saturation
    logic [PW-1:0] prod, prod_sh;
    assign prod    = PW'(width_reg) * PW'(urd_pkg::DIST_MUL);
    assign prod_sh = prod >> urd_pkg::DIST_SHR;

    // decimal split: divide by ten with a reciprocal multiply
    logic [26:0] dig_prod;
    logic [13:0] dig_quo, dig_rem;
    assign dig_prod = 27'(dig_val_reg) * 27'(urd_pkg::DEC_RECIP);
    assign dig_quo  = 14'(dig_prod >> urd_pkg::DEC_SHR);
    assign dig_rem  = dig_val_reg - dig_quo * urd_pkg::DEC_BASE;

    // interval selection
    logic [15:0]   scale1;
    logic [16:0]   twice;
    logic [15:0]   iv_direct;
    logic          far_side, near_side;
    logic [7:0]    den;
    logic [16:0]   near_num;
    logic [36:0]   near_prod;
    logic [15:0]   near_iv;
    logic [DW-1:0] div_dvd, q_sat_src;
    logic [VW-1:0] div_dsr;
    logic          div_start, div_done;
    logic [DW-1:0] div_q;

    assign scale1    = (scale_reg == 16'd0) ? 16'd1 : scale_reg;
    assign twice     = {scale1, 1'b0};
    assign far_side  = dist_reg > far_reg;
    assign near_side = dist_reg < near_reg;
    assign den       = urd_pkg::DEN_BASE - dist_reg[7:0];

    // near band: scale / 25 rounded up, by reciprocal multiply
    assign near_num  = {1'b0, scale1} + urd_pkg::NEAR_BIAS;
    assign near_prod = 37'(near_num) * 37'(urd_pkg::NEAR_RECIP);
    assign near_iv   = 16'(near_prod >> urd_pkg::NEAR_SHR);
    assign iv_direct = (!far_side && near_side) ? near_iv :
                       (twice[16] ? 16'hFFFF : twice[15:0]);

    always_comb begin
        sts.capture    = capture_now;
        sts.last_digit = (dig_idx_reg == '0);
        sts.iv_div     = !far_side && !near_side &&
                         (dist_reg < 14'(urd_pkg::BAND_TOP));
        sts.div_done   = div_done;
        sts.out_free   = !mv_reg || m_ready;
    end

    // middle band: scale * 10 / (210 - d) rounded up, on the serial divider
    assign div_dvd   = DW'(scale1) * DW'(10) + DW'(den) - DW'(1);
    assign div_dsr   = den;
    assign div_start = cmd.iv_go;
    assign q_sat_src = div_q;

    urd_div #(.DW(DW), .VW(VW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quot     (div_q)
    );

    // captured distance, digits and interval
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= '0;
            iv_reg   <= urd_pkg::SCALE_RST;
            for (int k = 0; k < NUM_DIGITS; k++) digit_store[k] <= '0;
        end else begin
            if (cmd.mul) begin
                dist_reg <= (prod_sh > PW'(urd_pkg::DIST_MAX)) ?
                            urd_pkg::DIST_MAX : prod_sh[13:0];
            end
            if (cmd.dig_store) digit_store[dig_idx_reg] <= dig_rem[3:0];
            if (cmd.iv_direct) iv_reg <= iv_direct;
            if (cmd.iv_store) begin
                iv_reg <= (q_sat_src > DW'(16'hFFFF)) ? 16'hFFFF :
                          (q_sat_src == '0) ? 16'd1 : q_sat_src[15:0];
            end
        end
    end

    // walk the digits from least significant up
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            dig_idx_reg <= SW'(NUM_DIGITS - 1);
            dig_val_reg <= (prod_sh > PW'(urd_pkg::DIST_MAX)) ?
                           urd_pkg::DIST_MAX : prod_sh[13:0];
        end else if (cmd.dig_store) begin
            dig_idx_reg <= dig_idx_reg - 1'b1;
            dig_val_reg <= dig_quo;
        end
    end

    // blink and scan update for the finished beat
    logic [15:0]   bc1;
    logic          toggle;
    logic [SW-1:0] si;
    logic [3:0]    digit;
    logic [7:0]    h1;
    logic          step;

    assign bc1    = bcnt_reg + 1'b1;
    assign toggle = bc1 >= iv_reg;
    assign si     = (32'(scan_reg) >= NUM_DIGITS) ? '0 : scan_reg;
    assign digit  = (digit_store[si] > 4'd9) ? 4'd0 : digit_store[si];
    assign h1     = hold_reg + 1'b1;
    assign step   = h1 >= ((hold_cfg_reg == 8'd0) ? 8'd1 : hold_cfg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcnt_reg <= '0;
            led_reg  <= 1'b0;
            scan_reg <= '0;
            hold_reg <= '0;
        end else if (cmd.commit) begin
            bcnt_reg <= toggle ? 16'd0 : bc1;
            led_reg  <= led_reg ^ toggle;
            hold_reg <= step ? 8'd0 : h1;
            if (step) begin
                scan_reg <= (32'(si) == NUM_DIGITS - 1) ? '0 : si + 1'b1;
            end else begin
                scan_reg <= si;
            end
        end
    end

    // output register: hold until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.commit) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            o_trig_reg <= trig_reg;
            o_seg_reg  <= urd_pkg::urd_seg(digit);
            o_en_reg   <= ~(4'b0001 << si);
            o_led_reg  <= led_reg ^ toggle;
            o_dist_reg <= dist_reg;
            o_new_reg  <= fresh_reg;
        end
    end

    assign m_valid          = mv_reg;
    assign m_trigger_out    = o_trig_reg;
    assign m_segment_lines  = o_seg_reg;
    assign m_digit_enable_n = o_en_reg;
    assign m_led_out        = o_led_reg;
    assign m_distance_cm    = o_dist_reg;
    assign m_distance_new   = o_new_reg;
endmodule
